// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ECC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ECC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ecc_pkg.sv -----
// ----------------------------------------------------------------------------
// ecc_pkg
// Types, constants and calendar helper functions of the epoch converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

	localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
	localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
	localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
	localparam logic [31:0] SECS_DAY         = 32'd86400;
	localparam logic [31:0] SECS_HOUR        = 32'd3600;
	localparam logic [31:0] SECS_MINUTE      = 32'd60;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic init;
		logic step;
	} yr_ctl_t;

	typedef struct packed {
		logic [11:0] year;
		logic        leap;
	} yr_stat_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] res;
		logic        ge;
	} alu_rsp_t;

	// The quotient by 100 comes from a reciprocal that is exact below 4096.
	function automatic logic ecc_is_leap(input logic [11:0] y);
		logic [24:0] prod;
		logic [5:0]  q;
		logic [11:0] qh;
		logic [11:0] r;
		prod = 25'(y) * 25'd5243;
		q    = prod[24:19];
		qh   = 12'(q) * 12'd100;
		r    = y - qh;
		return (y[1:0] == 2'd0) && ((r != 12'd0) || (q[1:0] == 2'd0));
	endfunction

	function automatic logic [4:0] ecc_days_of_month(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		if (m < 4'd1 || m > 4'd12) begin
			d = 5'd0;
		end else if (m == 4'd2 && leap) begin
			d = 5'd29;
		end else begin
			d = MONTH_LEN[m - 4'd1];
		end
		return d;
	endfunction

	function automatic logic [31:0] ecc_month_secs(input logic [4:0] d);
		logic [31:0] s;
		case (d)
			5'd28:   s = 32'd2419200;
			5'd29:   s = 32'd2505600;
			5'd30:   s = 32'd2592000;
			5'd31:   s = 32'd2678400;
			default: s = 32'd0;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] ecc_year_secs(input logic leap);
		return leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
	endfunction

	function automatic logic [2:0] ecc_wd_add(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
	endfunction

	function automatic logic [2:0] ecc_mod7(input logic [4:0] d);
		logic [4:0] r;
		r = d;
		if (r >= 5'd28) r = r - 5'd28;
		if (r >= 5'd14) r = r - 5'd14;
		if (r >= 5'd7)  r = r - 5'd7;
		return r[2:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/epoch_calendar_converter.sv -----
// ----------------------------------------------------------------------------
// epoch_calendar_converter
// Converts seconds since 1970 to a Gregorian date and time, and back.
// ----------------------------------------------------------------------------
// One beat is worked at a time by a sequencer around a single 32-bit adder.
// Opcode 0 makes one adder pass per whole year since 1970 and per whole
// month in the last year, then 16 restoring compare and subtract steps for
// day, hour and minute. Opcode 1 makes one adder pass per year, per month
// and per day and time term, with one more pass that takes off a day.
// A finished result waits in the output register while the next beat is
// taken.
`default_nettype none

`include "assert_macros.svh"

module epoch_calendar_converter
	import ecc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] epoch_seconds_in,
	input  logic [11:0] cal_year,
	input  logic [3:0]  cal_month,
	input  logic [4:0]  cal_day,
	input  logic [4:0]  cal_hours,
	input  logic [5:0]  cal_minutes,
	input  logic [5:0]  cal_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] epoch_seconds_out,
	output logic [11:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [4:0]  out_hours,
	output logic [5:0]  out_minutes,
	output logic [5:0]  out_seconds,
	output logic [2:0]  out_weekday
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_YEAR,
		S_MONTH,
		S_DAY,
		S_HOUR,
		S_MIN,
		S_DTERM,
		S_DFIX,
		S_HTERM,
		S_MTERM,
		S_STERM,
		S_DONE
	} state_t;

	localparam logic [2:0]  K_DAY    = 3'd4;
	localparam logic [2:0]  K_HOUR   = 3'd4;
	localparam logic [2:0]  K_MIN    = 3'd5;
	localparam logic [2:0]  WD_EPOCH = 3'd4;
	localparam logic [11:0] MAX_YEAR = 12'd2106;

	state_t      state_q;
	logic        op_q;
	logic [31:0] acc_q;
	logic [3:0]  m_q;
	logic [2:0]  wd_q;
	logic [2:0]  k_q;
	logic [5:0]  qacc_q;
	logic [4:0]  day_q;
	logic [4:0]  hrs_q;
	logic [5:0]  min_q;
	logic        leap_in_q;
	logic [11:0] cal_year_q;
	logic [3:0]  cal_month_q;
	logic [4:0]  cal_day_q;
	logic [4:0]  cal_hours_q;
	logic [5:0]  cal_minutes_q;
	logic [5:0]  cal_seconds_q;
	logic        out_valid_q;
	logic [31:0] epoch_seconds_out_q;
	logic [11:0] out_year_q;
	logic [3:0]  out_month_q;
	logic [4:0]  out_day_q;
	logic [4:0]  out_hours_q;
	logic [5:0]  out_minutes_q;
	logic [5:0]  out_seconds_q;
	logic [2:0]  out_weekday_q;

	yr_ctl_t     yr_ctl;
	yr_stat_t    yr_stat;
	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;

	logic        in_fire;
	logic        leap_m;
	logic [4:0]  dom;
	logic [31:0] div_base;
	logic [31:0] div_b;
	logic        year_more;
	logic        month_more;
	logic [5:0]  q_next;
	logic [2:0]  wd_final;
	logic        res_one_form;
	logic        res_date_ok;
	logic        yr_in_range;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign leap_m     = op_q ? leap_in_q : yr_stat.leap;
	assign dom        = ecc_days_of_month(m_q, leap_m);
	assign year_more  = (yr_stat.year < cal_year_q);
	assign month_more = op_q ? (m_q < cal_month_q) : ((m_q <= 4'd12) && alu_rsp.ge);
	assign q_next     = {qacc_q[4:0], alu_rsp.ge};
	assign wd_final   = ecc_wd_add(wd_q, ecc_mod7(day_q));

	always_comb begin
		case (state_q)
			S_DAY:   div_base = SECS_DAY;
			S_HOUR:  div_base = SECS_HOUR;
			default: div_base = SECS_MINUTE;
		endcase
		div_b = div_base << k_q;
	end

	always_comb begin
		alu_req.a   = acc_q;
		alu_req.b   = 32'd0;
		alu_req.sub = 1'b0;
		case (state_q)
			S_YEAR: begin
				alu_req.b   = ecc_year_secs(yr_stat.leap);
				alu_req.sub = !op_q;
			end
			S_MONTH: begin
				alu_req.b   = ecc_month_secs(dom);
				alu_req.sub = !op_q;
			end
			S_DAY, S_HOUR, S_MIN: begin
				alu_req.b   = div_b;
				alu_req.sub = 1'b1;
			end
			S_DTERM: alu_req.b = {27'd0, cal_day_q} * SECS_DAY;
			S_DFIX: begin
				alu_req.b   = SECS_DAY;
				alu_req.sub = 1'b1;
			end
			S_HTERM: alu_req.b = {27'd0, cal_hours_q} * SECS_HOUR;
			S_MTERM: alu_req.b = {26'd0, cal_minutes_q} * SECS_MINUTE;
			S_STERM: alu_req.b = {26'd0, cal_seconds_q};
			default: alu_req.b = 32'd0;
		endcase
	end

	always_comb begin
		yr_ctl.init = in_fire;
		yr_ctl.step = (state_q == S_YEAR) && (op_q ? year_more : alu_rsp.ge);
	end

	ecc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ecc_year_ctr u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (yr_ctl),
		.stat   (yr_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_IDLE;
			op_q                <= 1'b0;
			acc_q               <= 32'd0;
			m_q                 <= 4'd1;
			wd_q                <= WD_EPOCH;
			k_q                 <= 3'd0;
			qacc_q              <= 6'd0;
			day_q               <= 5'd0;
			hrs_q               <= 5'd0;
			min_q               <= 6'd0;
			leap_in_q           <= 1'b0;
			cal_year_q          <= 12'd0;
			cal_month_q         <= 4'd0;
			cal_day_q           <= 5'd0;
			cal_hours_q         <= 5'd0;
			cal_minutes_q       <= 6'd0;
			cal_seconds_q       <= 6'd0;
			out_valid_q         <= 1'b0;
			epoch_seconds_out_q <= 32'd0;
			out_year_q          <= 12'd0;
			out_month_q         <= 4'd0;
			out_day_q           <= 5'd0;
			out_hours_q         <= 5'd0;
			out_minutes_q       <= 6'd0;
			out_seconds_q       <= 6'd0;
			out_weekday_q       <= 3'd0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q          <= opcode;
						acc_q         <= opcode ? 32'd0 : epoch_seconds_in;
						m_q           <= 4'd1;
						wd_q          <= WD_EPOCH;
						leap_in_q     <= ecc_is_leap(cal_year);
						cal_year_q    <= cal_year;
						cal_month_q   <= cal_month;
						cal_day_q     <= cal_day;
						cal_hours_q   <= cal_hours;
						cal_minutes_q <= cal_minutes;
						cal_seconds_q <= cal_seconds;
						state_q       <= S_YEAR;
					end
				end
				S_YEAR: begin
					if (op_q) begin
						if (year_more) begin
							acc_q <= alu_rsp.res;
						end else begin
							state_q <= S_MONTH;
						end
					end else if (alu_rsp.ge) begin
						acc_q <= alu_rsp.res;
						wd_q  <= ecc_wd_add(wd_q, yr_stat.leap ? 3'd2 : 3'd1);
					end else begin
						state_q <= S_MONTH;
					end
				end
				S_MONTH: begin
					if (month_more) begin
						acc_q <= alu_rsp.res;
						m_q   <= m_q + 4'd1;
						if (!op_q) begin
							wd_q <= ecc_wd_add(wd_q, 3'(dom - 5'd28));
						end
					end else if (op_q) begin
						state_q <= S_DTERM;
					end else begin
						state_q <= S_DAY;
						k_q     <= K_DAY;
						qacc_q  <= 6'd0;
					end
				end
				S_DAY, S_HOUR, S_MIN: begin
					if (alu_rsp.ge) begin
						acc_q <= alu_rsp.res;
					end
					if (k_q == 3'd0) begin
						qacc_q <= 6'd0;
						case (state_q)
							S_DAY: begin
								day_q   <= q_next[4:0];
								k_q     <= K_HOUR;
								state_q <= S_HOUR;
							end
							S_HOUR: begin
								hrs_q   <= q_next[4:0];
								k_q     <= K_MIN;
								state_q <= S_MIN;
							end
							default: begin
								min_q   <= q_next;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						qacc_q <= q_next;
						k_q    <= k_q - 3'd1;
					end
				end
				S_DTERM: begin
					acc_q   <= alu_rsp.res;
					state_q <= S_DFIX;
				end
				S_DFIX: begin
					acc_q   <= alu_rsp.res;
					state_q <= S_HTERM;
				end
				S_HTERM: begin
					acc_q   <= alu_rsp.res;
					state_q <= S_MTERM;
				end
				S_MTERM: begin
					acc_q   <= alu_rsp.res;
					state_q <= S_STERM;
				end
				S_STERM: begin
					acc_q   <= alu_rsp.res;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (op_q) begin
							epoch_seconds_out_q <= acc_q;
							out_year_q          <= 12'd0;
							out_month_q         <= 4'd0;
							out_day_q           <= 5'd0;
							out_hours_q         <= 5'd0;
							out_minutes_q       <= 6'd0;
							out_seconds_q       <= 6'd0;
							out_weekday_q       <= 3'd0;
						end else begin
							epoch_seconds_out_q <= 32'd0;
							out_year_q          <= yr_stat.year;
							out_month_q         <= m_q;
							out_day_q           <= day_q + 5'd1;
							out_hours_q         <= hrs_q;
							out_minutes_q       <= min_q;
							out_seconds_q       <= acc_q[5:0];
							out_weekday_q       <= (wd_final == 3'd0) ? 3'd7 : wd_final;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign epoch_seconds_out = epoch_seconds_out_q;
	assign out_year          = out_year_q;
	assign out_month         = out_month_q;
	assign out_day           = out_day_q;
	assign out_hours         = out_hours_q;
	assign out_minutes       = out_minutes_q;
	assign out_seconds       = out_seconds_q;
	assign out_weekday       = out_weekday_q;

	assign res_one_form = (epoch_seconds_out == 32'd0) ||
		((out_year == 12'd0) && (out_month == 4'd0) && (out_weekday == 3'd0));
	assign res_date_ok  = (out_year == 12'd0) ||
		((out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1) &&
		(out_weekday != 3'd0));
	assign yr_in_range  = (state_q != S_YEAR) || op_q || (yr_stat.year <= MAX_YEAR);

	`ECC_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "new beat taken while busy")
	`ECC_ASSERT(a_unused_zero, out_valid |-> res_one_form, "both result forms nonzero")
	`ECC_ASSERT(a_date_sane, out_valid |-> res_date_ok, "calendar result out of range")
	`ECC_ASSERT(a_year_bound, yr_in_range, "year loop ran past the 32-bit range")

endmodule

`default_nettype wire

// ----- rtl/ecc_alu.sv -----
// ----------------------------------------------------------------------------
// ecc_alu
// Shared 32-bit adder and subtractor with a carry flag that gives unsigned greater-or-equal on a subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_alu
	import ecc_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [31:0] b_eff;
	logic [32:0] sum;

	assign b_eff   = req.sub ? ~req.b : req.b;
	assign sum     = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, req.sub};
	assign rsp.res = sum[31:0];
	assign rsp.ge  = sum[32];

endmodule

`default_nettype wire

// ----- rtl/ecc_year_ctr.sv -----
// ----------------------------------------------------------------------------
// ecc_year_ctr
// Year counter from 1970 with running residues that give the leap flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ecc_year_ctr
	import ecc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  yr_ctl_t  ctl,
	output yr_stat_t stat
);

	logic [11:0] year_q;
	logic [1:0]  m4_q;
	logic [6:0]  m100_q;
	logic [1:0]  c4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= EPOCH_YEAR;
			m4_q   <= 2'd2;
			m100_q <= 7'd70;
			c4_q   <= 2'd3;
		end else if (ctl.init) begin
			year_q <= EPOCH_YEAR;
			m4_q   <= 2'd2;
			m100_q <= 7'd70;
			c4_q   <= 2'd3;
		end else if (ctl.step) begin
			year_q <= year_q + 12'd1;
			m4_q   <= m4_q + 2'd1;
			if (m100_q == 7'd99) begin
				m100_q <= 7'd0;
				c4_q   <= c4_q + 2'd1;
			end else begin
				m100_q <= m100_q + 7'd1;
			end
		end
	end

	assign stat.year = year_q;
	assign stat.leap = (m4_q == 2'd0) && ((m100_q != 7'd0) || (c4_q == 2'd0));

	`ECC_ASSERT(a_leap_track, stat.leap == ecc_is_leap(stat.year), "leap residues out of step")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: epoch calendar converter testbench
// A driver pushes beats of both opcodes, first a directed set and then random
// ones, into the converter. A monitor predicts each result at input accept
// time and checks every output beat, field by field, in order. The sender and
// receiver idle in three patterns, and there are two long output stalls and
// two drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ecc_pkg::SECS_DAY;
	import ecc_pkg::SECS_HOUR;
	import ecc_pkg::SECS_MINUTE;
	import ecc_pkg::SECS_LEAP_YEAR;
	import ecc_pkg::SECS_COMMON_YEAR;

	localparam bit OP_TO_CALENDAR = 1'b0;
	localparam bit OP_TO_EPOCH    = 1'b1;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_BEATS   = 560;
	localparam int DRAIN_INDEX    = 100;
	localparam int LONG_HOLD      = 600;
	localparam int TAIL_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 20_000_000;
	localparam int unsigned FIRST_YEAR = 1970;
	localparam int unsigned LAST_YEAR  = 2106;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		bit        op;
		bit [31:0] secs;
		bit [11:0] year;
		bit [3:0]  month;
		bit [4:0]  day;
		bit [4:0]  hours;
		bit [5:0]  minutes;
		bit [5:0]  seconds;
		bit        drain_first;
	} calendar_request_t;

	typedef struct {
		bit [31:0] epoch;
		bit [11:0] year;
		bit [3:0]  month;
		bit [4:0]  day;
		bit [4:0]  hours;
		bit [5:0]  minutes;
		bit [5:0]  seconds;
		bit [2:0]  weekday;
	} conversion_t;

	logic        clk;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic        in_ready;
	logic        opcode           = 1'b0;
	logic [31:0] epoch_seconds_in = '0;
	logic [11:0] cal_year         = '0;
	logic [3:0]  cal_month        = '0;
	logic [4:0]  cal_day          = '0;
	logic [4:0]  cal_hours        = '0;
	logic [5:0]  cal_minutes      = '0;
	logic [5:0]  cal_seconds      = '0;
	logic        out_valid;
	logic        out_ready        = 1'b0;
	logic [31:0] epoch_seconds_out;
	logic [11:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [4:0]  out_hours;
	logic [5:0]  out_minutes;
	logic [5:0]  out_seconds;
	logic [2:0]  out_weekday;

	calendar_request_t queued_requests[$];
	conversion_t       awaited_conversions[$];

	logic in_taken          = 1'b0;
	int   sender_idle_pct   = 18;
	int   receiver_idle_pct = 53;
	int   holds_asked       = 0;
	int   holds_granted     = 0;
	int   hold_left         = 0;
	int   cycle_count       = 0;
	int   fail_count        = 0;
	int   date_checks       = 0;
	int   epoch_checks      = 0;
	int   odd_dates         = 0;

	epoch_calendar_converter DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.epoch_seconds_in  (epoch_seconds_in),
		.cal_year          (cal_year),
		.cal_month         (cal_month),
		.cal_day           (cal_day),
		.cal_hours         (cal_hours),
		.cal_minutes       (cal_minutes),
		.cal_seconds       (cal_seconds),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.epoch_seconds_out (epoch_seconds_out),
		.out_year          (out_year),
		.out_month         (out_month),
		.out_day           (out_day),
		.out_hours         (out_hours),
		.out_minutes       (out_minutes),
		.out_seconds       (out_seconds),
		.out_weekday       (out_weekday)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		if (m < 1 || m > 12) begin
			return 0;
		end
		if (m == 2 && is_leap_year(y)) begin
			return 29;
		end
		return MONTH_DAYS[m - 1];
	endfunction

	function automatic bit [31:0] year_length(input int unsigned y);
		return is_leap_year(y) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
	endfunction

	function automatic conversion_t convert_beat(input calendar_request_t r);
		conversion_t res;
		bit [31:0]   rest;
		bit [31:0]   sum;
		bit [31:0]   wd;
		int unsigned y;
		int unsigned m;
		res = '{default: '0};
		if (r.op == OP_TO_CALENDAR) begin
			rest = r.secs;
			y = FIRST_YEAR;
			m = 1;
			while (rest >= year_length(y)) begin
				rest = rest - year_length(y);
				y++;
			end
			while (m <= 12 && rest >= month_length(m, y) * SECS_DAY) begin
				rest = rest - month_length(m, y) * SECS_DAY;
				m++;
			end
			wd = (r.secs / SECS_DAY + 4) % 7;
			if (wd == 0) begin
				wd = 7;
			end
			res.year    = 12'(y);
			res.month   = 4'(m);
			res.day     = 5'(rest / SECS_DAY + 1);
			rest        = rest % SECS_DAY;
			res.hours   = 5'(rest / SECS_HOUR);
			rest        = rest % SECS_HOUR;
			res.minutes = 6'(rest / SECS_MINUTE);
			res.seconds = 6'(rest % SECS_MINUTE);
			res.weekday = 3'(wd);
		end else begin
			sum = '0;
			for (y = FIRST_YEAR; y < r.year; y++) begin
				sum = sum + year_length(y);
			end
			for (m = 1; m < r.month; m++) begin
				sum = sum + month_length(m, r.year) * SECS_DAY;
			end
			sum = sum + r.day * SECS_DAY - SECS_DAY;
			sum = sum + r.hours * SECS_HOUR;
			sum = sum + r.minutes * SECS_MINUTE;
			sum = sum + r.seconds;
			res.epoch = sum;
		end
		return res;
	endfunction

	function automatic calendar_request_t date_beat(input int unsigned y, input int unsigned m,
			input int unsigned d, input int unsigned h, input int unsigned mi,
			input int unsigned s);
		calendar_request_t r;
		r.op          = OP_TO_EPOCH;
		r.secs        = $urandom;
		r.year        = 12'(y);
		r.month       = 4'(m);
		r.day         = 5'(d);
		r.hours       = 5'(h);
		r.minutes     = 6'(mi);
		r.seconds     = 6'(s);
		r.drain_first = 1'b0;
		return r;
	endfunction

	function automatic calendar_request_t secs_beat(input bit [31:0] s);
		calendar_request_t r;
		r = date_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		r.op   = OP_TO_CALENDAR;
		r.secs = s;
		return r;
	endfunction

	function automatic calendar_request_t random_date(input int unsigned y);
		int unsigned m;
		m = $urandom_range(12, 1);
		return date_beat(y, m, $urandom_range(month_length(m, y), 1), $urandom_range(23),
			$urandom_range(59), $urandom_range(59));
	endfunction

	function automatic calendar_request_t random_request();
		calendar_request_t r;
		calendar_request_t d;
		int unsigned       pick;
		pick = $urandom_range(99);
		if ($urandom_range(1) == OP_TO_EPOCH) begin
			if (pick < 4) begin
				r = random_date($urandom_range(4095));
			end else if (pick < 8) begin
				r = random_date($urandom_range(FIRST_YEAR - 1));
			end else begin
				r = random_date($urandom_range(LAST_YEAR, FIRST_YEAR));
			end
			if ($urandom_range(99) < 6) begin
				r.month = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
			end
			if ($urandom_range(99) < 6) begin
				r.day = 5'($urandom);
			end
			if ($urandom_range(99) < 6) begin
				r.hours = 5'($urandom);
			end
			if ($urandom_range(99) < 6) begin
				r.minutes = 6'($urandom);
			end
			if ($urandom_range(99) < 6) begin
				r.seconds = 6'($urandom);
			end
		end else if (pick < 40) begin
			// Land on or next to a year, month or day rollover.
			d = random_date($urandom_range(LAST_YEAR, FIRST_YEAR));
			d.hours   = '0;
			d.minutes = '0;
			d.seconds = '0;
			if ($urandom_range(1) == 0) begin
				d.day = 5'd1;
			end
			r = secs_beat(convert_beat(d).epoch + 32'($urandom_range(2)) - 32'd1);
		end else begin
			r = secs_beat($urandom);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input bit [31:0] want, input bit [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin : drive_requests
		calendar_request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
					!(queued_requests[0].drain_first && awaited_conversions.size() != 0)) begin
				r = queued_requests.pop_front();
				in_valid         <= 1'b1;
				opcode           <= r.op;
				epoch_seconds_in <= r.secs;
				cal_year         <= r.year;
				cal_month        <= r.month;
				cal_day          <= r.day;
				cal_hours        <= r.hours;
				cal_minutes      <= r.minutes;
				cal_seconds      <= r.seconds;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (holds_granted != holds_asked) begin
			holds_granted <= holds_granted + 1;
			hold_left     <= LONG_HOLD;
			out_ready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin : watch_ports
		calendar_request_t r;
		conversion_t       want;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_conversions.size() == 0) begin
				$error("output beat arrived with no conversion pending");
				fail_count++;
			end else begin
				want = awaited_conversions.pop_front();
				check_field("epoch_seconds_out", want.epoch, epoch_seconds_out);
				check_field("out_year", want.year, out_year);
				check_field("out_month", want.month, out_month);
				check_field("out_day", want.day, out_day);
				check_field("out_hours", want.hours, out_hours);
				check_field("out_minutes", want.minutes, out_minutes);
				check_field("out_seconds", want.seconds, out_seconds);
				check_field("out_weekday", want.weekday, out_weekday);
			end
		end
		if (arst_n && in_valid && in_ready) begin
			r = date_beat(cal_year, cal_month, cal_day, cal_hours, cal_minutes, cal_seconds);
			r.op   = opcode;
			r.secs = epoch_seconds_in;
			awaited_conversions.push_back(convert_beat(r));
			if (r.op == OP_TO_CALENDAR) begin
				date_checks++;
			end else begin
				epoch_checks++;
				if (r.year < FIRST_YEAR || r.year > LAST_YEAR || r.month == 0 || r.month > 12 ||
						r.day == 0 || r.hours > 23 || r.minutes > 59 || r.seconds > 59) begin
					odd_dates++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin : run_stimulus
		calendar_request_t r;
		int                phase;
		int                k;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0, 1: begin
					sender_idle_pct   = 18;
					receiver_idle_pct = 53;
				end
				2: begin
					sender_idle_pct   = 53;
					receiver_idle_pct = 18;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				queued_requests.push_back(secs_beat(32'd0));
				queued_requests.push_back(secs_beat(32'hFFFF_FFFF));
				queued_requests.push_back(secs_beat(32'h8000_0000));
				queued_requests.push_back(secs_beat(32'd31535999));
				queued_requests.push_back(secs_beat(32'd31536000));
				queued_requests.push_back(secs_beat(32'd68169600));
				queued_requests.push_back(secs_beat(32'd259200));
				queued_requests.push_back(secs_beat(32'd951782400));
				queued_requests.push_back(secs_beat(32'd951868800));
				queued_requests.push_back(secs_beat(32'd4107542399));
				queued_requests.push_back(secs_beat(32'd4107542400));
				queued_requests.push_back(date_beat(1970, 1, 1, 0, 0, 0));
				queued_requests.push_back(date_beat(2106, 2, 7, 6, 28, 15));
				queued_requests.push_back(date_beat(2106, 12, 31, 23, 59, 59));
				queued_requests.push_back(date_beat(2000, 2, 29, 12, 30, 30));
				queued_requests.push_back(date_beat(2100, 3, 1, 0, 0, 0));
				queued_requests.push_back(date_beat(2038, 1, 19, 3, 14, 7));
				queued_requests.push_back(date_beat(1969, 6, 15, 10, 0, 0));
				queued_requests.push_back(date_beat(0, 1, 1, 0, 0, 0));
				queued_requests.push_back(date_beat(4095, 15, 31, 31, 63, 63));
				queued_requests.push_back(date_beat(2024, 0, 0, 0, 0, 0));
				queued_requests.push_back(date_beat(2023, 13, 1, 0, 0, 0));
				queued_requests.push_back(date_beat(1970, 1, 0, 0, 0, 0));
				queued_requests.push_back(date_beat(2048, 14, 2, 24, 60, 60));
			end else begin
				for (k = 0; k < RANDOM_BEATS; k++) begin
					r = random_request();
					r.drain_first = (phase != 3 && k == DRAIN_INDEX);
					queued_requests.push_back(r);
				end
				if (phase != 3) begin
					holds_asked++;
				end
			end
			while (queued_requests.size() != 0 || in_valid) @(posedge clk);
		end
		while (awaited_conversions.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d seconds-to-date and %0d date-to-seconds conversions, %0d of them",
			date_checks, epoch_checks, odd_dates);
		$display("with date fields out of calendar range; %0d long output stalls, %0d cycles.",
			holds_granted, cycle_count);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/ecc_pkg.sv
rtl/ecc_alu.sv
rtl/ecc_year_ctr.sv
rtl/epoch_calendar_converter.sv
dv/tb.sv
